### design/dfdl_pkg.sv
package dfdl_pkg;

  // Line geometry
  localparam int LINE_DEPTH  = 262144;
  localparam int PTR_W       = $clog2(LINE_DEPTH);
  localparam int CNT_W       = $clog2(LINE_DEPTH + 1);

  // Field widths
  localparam int SAMPLE_BITS = 24;
  localparam int DT_W        = 22;
  localparam int GAIN_W      = 16;
  localparam int SR_W        = 18;
  localparam int LL_W        = 19;
  localparam int CFG_W       = (SR_W > LL_W) ? SR_W : LL_W;
  localparam int CAPX_W      = (LL_W > CNT_W) ? LL_W : CNT_W;

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS     = SAMPLE_BITS + DT_W + GAIN_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register indexes
  localparam logic REG_SAMPLE_RATE = 1'b0;
  localparam logic REG_LINE_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_READ,
    ST_PROD,
    ST_DONE
  } state_e;

  // One strobe per datapath step
  typedef struct packed {
    logic load;
    logic mul;
    logic wr;
    logic rd;
    logic prod;
    logic emit;
  } cmd_t;

endpackage

### design/dfdl_ctrl.sv
module dfdl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dfdl_pkg::cmd_t cmd_o
);
  import dfdl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_WRITE;
      ST_WRITE: state_d = ST_READ;
      ST_READ:  state_d = ST_PROD;
      ST_PROD:  state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:   cmd_o.mul  = 1'b1;
      ST_WRITE: cmd_o.wr   = 1'b1;
      ST_READ:  cmd_o.rd   = 1'b1;
      ST_PROD:  cmd_o.prod = 1'b1;
      ST_DONE:  cmd_o.emit = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/dfdl_datapath.sv
module dfdl_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dfdl_pkg::cmd_t                       cmd_i,
  input  logic signed [dfdl_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic [dfdl_pkg::DT_W-1:0]            delay_time_i,
  input  logic signed [dfdl_pkg::GAIN_W-1:0]   diffusion_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [dfdl_pkg::CFG_W-1:0]           cfg_data_i,
  output logic signed [dfdl_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                 delay_clamped_o
);
  import dfdl_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int MGX_W  = GAIN_W + SB;
  localparam int RND_W  = MGX_W + 1;
  localparam int SCL_W  = RND_W - 15;
  localparam int PO_W   = DT_W + SR_W;
  localparam int OFF_W  = PO_W - 4;
  localparam int DIF_W  = SB + 1;
  localparam int FP_W   = 17 + DIF_W;
  localparam int TRM_W  = FP_W + 1 - 16;
  localparam int SUM_W  = SB + 6;

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-SB:0] top;
    begin
      top = v[SUM_W-1:SB-1];
      if (top == '0 || top == '1) begin
        sat_sample = v[SB-1:0];
      end else begin
        sat_sample = {v[SUM_W-1], {(SB-1){~v[SUM_W-1]}}};
      end
    end
  endfunction

  // Configuration
  logic [SR_W-1:0] sr_q;
  logic [LL_W-1:0] ll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= SR_W'(48000);
      ll_q <= LL_W'(262144);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_RATE: sr_q <= cfg_data_i[SR_W-1:0];
        REG_LINE_LENGTH: ll_q <= cfg_data_i[LL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CAPX_W-1:0] ll_x;
  logic [CNT_W-1:0]  cap;

  always_comb begin
    ll_x = CAPX_W'(ll_q);
    if (ll_x > CAPX_W'(LINE_DEPTH)) begin
      cap = CNT_W'(LINE_DEPTH);
    end else if (ll_x < CAPX_W'(2)) begin
      cap = CNT_W'(2);
    end else begin
      cap = CNT_W'(ll_x);
    end
  end

  // State
  logic [PTR_W-1:0]        wp_q, wp_d;
  logic [CNT_W-1:0]        hw_q, hw_d;
  logic signed [SB-1:0]    prev_q;

  // Item payload and intermediates
  logic signed [SB-1:0]     x_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [GAIN_W-1:0] g_q;
  logic signed [MGX_W-1:0]  p_fb_q, p_ff_q;
  logic [PO_W-1:0]          p_off_q;
  logic [PTR_W-1:0]         i1_q, i2_q;
  logic [15:0]              f_q;
  logic                     clamp_q;
  logic [SB-1:0]            rd_a_q, rd_b_q;
  logic                     va_q, vb_q;
  logic signed [SB-1:0]     a_q;
  logic signed [FP_W-1:0]   p_int_q;
  logic signed [SB-1:0]     y_q;
  logic                     y_clamp_q;

  logic [SB-1:0] mem [LINE_DEPTH];

  // Write step
  logic [PTR_W-1:0]        wp_eff;
  logic signed [RND_W-1:0] fb_rnd;
  logic signed [SCL_W-1:0] fb_s;
  logic signed [SB-1:0]    w_val;
  logic [OFF_W-1:0]        off, lim, off_c;
  logic                    clamp;
  logic [CNT_W-1:0]        n;
  logic [CNT_W:0]          i1_sum;
  logic [PTR_W-1:0]        i1, i2;

  always_comb begin
    wp_eff = (CNT_W'(wp_q) < cap) ? wp_q : '0;
    fb_rnd = RND_W'(p_fb_q) + RND_W'(16384);
    fb_s   = $signed(fb_rnd[RND_W-1:15]);
    w_val  = sat_sample(SUM_W'(x_q) + SUM_W'(fb_s));

    off   = p_off_q[PO_W-1:4];
    lim   = OFF_W'(cap - CNT_W'(1)) << 16;
    clamp = off > lim;
    off_c = clamp ? lim : off;
    n     = CNT_W'(off_c >> 16);

    i1_sum = (CNT_W+1)'(wp_eff) + (CNT_W+1)'(cap) - (CNT_W+1)'(n);
    if (i1_sum >= (CNT_W+1)'(cap)) begin
      i1_sum = i1_sum - (CNT_W+1)'(cap);
    end
    i1 = i1_sum[PTR_W-1:0];
    i2 = (CNT_W'(i1) + CNT_W'(1) >= cap) ? '0 : i1 + PTR_W'(1);

    wp_d = (CNT_W'(wp_eff) + CNT_W'(1) < cap) ? wp_eff + PTR_W'(1) : '0;
    hw_d = (CNT_W'(wp_eff) == hw_q) ? hw_q + CNT_W'(1) : hw_q;
  end

  // Mix step
  logic signed [SB-1:0]    a_m, b_m;
  logic signed [DIF_W-1:0] diff;
  logic signed [FP_W:0]    int_rnd;
  logic signed [TRM_W-1:0] term;
  logic signed [RND_W-1:0] ff_rnd;
  logic signed [SCL_W-1:0] ff_s;
  logic signed [SB-1:0]    y;

  always_comb begin
    a_m     = va_q ? $signed(rd_a_q) : '0;
    b_m     = vb_q ? $signed(rd_b_q) : '0;
    diff    = DIF_W'(b_m) - DIF_W'(a_m);
    int_rnd = (FP_W+1)'(p_int_q) + (FP_W+1)'(32768);
    term    = $signed(int_rnd[FP_W:16]);
    ff_rnd  = RND_W'(p_ff_q) + RND_W'(16384);
    ff_s    = $signed(ff_rnd[RND_W-1:15]);
    y       = sat_sample(SUM_W'(a_q) + SUM_W'(term) - SUM_W'(ff_s));
  end

  // Line memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wp_eff] <= w_val;
    end
    if (cmd_i.rd) begin
      rd_a_q <= mem[i1_q];
      rd_b_q <= mem[i2_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q  <= sample_in_i;
      dt_q <= delay_time_i;
      g_q  <= diffusion_i;
    end
    if (cmd_i.mul) begin
      p_fb_q  <= g_q * prev_q;
      p_off_q <= PO_W'(dt_q) * PO_W'(sr_q);
    end
    if (cmd_i.wr) begin
      p_ff_q  <= g_q * x_q;
      i1_q    <= i1;
      i2_q    <= i2;
      f_q     <= off_c[15:0];
      clamp_q <= clamp;
    end
    if (cmd_i.rd) begin
      va_q <= CNT_W'(i1_q) < hw_q;
      vb_q <= CNT_W'(i2_q) < hw_q;
    end
    if (cmd_i.prod) begin
      a_q     <= a_m;
      p_int_q <= $signed({1'b0, f_q}) * diff;
    end
    if (cmd_i.emit) begin
      y_q       <= y;
      y_clamp_q <= clamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      hw_q   <= '0;
      prev_q <= '0;
    end else begin
      if (cmd_i.wr) begin
        wp_q <= wp_d;
        hw_q <= hw_d;
      end
      if (cmd_i.emit) begin
        prev_q <= y;
      end
    end
  end

  assign sample_out_o    = y_q;
  assign delay_clamped_o = y_clamp_q;

endmodule

### design/diffused_fractional_delay_line_top.sv
// Diffused fractional delay line: a Schroeder allpass wrapped around a
// circular delay line with a linearly interpolated tap. Each input word
// writes sample_in plus diffusion times the previous output into the line,
// reads the line delay_time * sample_rate samples back (16 fractional bits,
// clamped to line length minus one) and returns the interpolated tap minus
// sample_in times diffusion, saturated to Q1.23. One item is in flight at a
// time: from acceptance, the item passes through the multiply, write,
// registered memory read, interpolation multiply and final mix steps of
// the sequencer before its result is in the output register, and a new word
// is taken only after that. The next word is accepted while a finished result
// still waits on the master side. The line is a single memory with one
// write and two read ports. After reset no clearing pass runs: a fill mark
// tracks how far the line has been written, and entries beyond it read as
// zero, so the block is ready right after reset.
// Write sample_rate and line_length only while the block is idle.
module diffused_fractional_delay_line_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_in [23:0], delay_time [45:24], diffusion [61:46], zero [63:62]
  input  logic [dfdl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Master side
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // sample_out [23:0], delay_clamped [24], zero [31:25]
  output logic [dfdl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [dfdl_pkg::CFG_W-1:0]          cfg_data_i
);
  import dfdl_pkg::*;

  cmd_t cmd;

  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [DT_W-1:0]               delay_time;
  logic signed [GAIN_W-1:0]      diffusion;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          delay_clamped;

  // Unpack the slave word
  assign sample_in  = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign delay_time = s_axis_tdata[SAMPLE_BITS +: DT_W];
  assign diffusion  = $signed(s_axis_tdata[SAMPLE_BITS+DT_W +: GAIN_W]);

  dfdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  dfdl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_in_i     (sample_in),
    .delay_time_i    (delay_time),
    .diffusion_i     (diffusion),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_out_o    (sample_out),
    .delay_clamped_o (delay_clamped)
  );

  // Pack the master word, zero-fill the pad bits
  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, delay_clamped, sample_out};

endmodule
